[hdl/sia_pkg.sv]
package sia_pkg;

  // operand width
  localparam int DATA_WIDTH = 32;

  // request codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_REM = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_MOD0  = 2'd2;
  localparam logic [1:0] ST_BADOP = 2'd3;

  // request word carried down the pipeline
  typedef struct packed {
    logic [2:0]            op;
    logic [1:0]            status;
    logic                  neg_q;
    logic                  neg_r;
    logic [DATA_WIDTH-1:0] side;
    logic [DATA_WIDTH-1:0] divisor;
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] quo;
  } sia_word_t;

endpackage

[hdl/sia_prep.sv]
module sia_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic [2:0]                    req_type_i,
  input  logic [sia_pkg::DATA_WIDTH-1:0] operand_a_i,
  input  logic [sia_pkg::DATA_WIDTH-1:0] operand_b_i,
  output logic                          vld_o,
  output sia_pkg::sia_word_t            word_o
);
  import sia_pkg::*;

  localparam logic [DATA_WIDTH-1:0] ONE  = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
  localparam logic [DATA_WIDTH-1:0] ZERO = '0;

  logic                    vld_r;
  sia_word_t               word_r;
  sia_word_t               word_nxt;
  logic [DATA_WIDTH-1:0]   prod;
  logic [DATA_WIDTH-1:0]   mag_a;
  logic [DATA_WIDTH-1:0]   mag_b;

  // product wrapped to the operand width, same for signed and unsigned operands
  assign prod = operand_a_i * operand_b_i;

  // operand magnitudes for the divider
  assign mag_a = operand_a_i[DATA_WIDTH-1] ? (~operand_a_i + ONE) : operand_a_i;
  assign mag_b = operand_b_i[DATA_WIDTH-1] ? (~operand_b_i + ONE) : operand_b_i;

  // decode and the add, subtract and multiply operations
  always_comb begin
    word_nxt.op      = req_type_i;
    word_nxt.neg_q   = operand_a_i[DATA_WIDTH-1] ^ operand_b_i[DATA_WIDTH-1];
    word_nxt.neg_r   = operand_a_i[DATA_WIDTH-1];
    word_nxt.divisor = mag_b;
    word_nxt.rem     = ZERO;
    word_nxt.quo     = mag_a;
    word_nxt.side    = ZERO;
    word_nxt.status  = ST_OK;
    case (req_type_i)
      OP_ADD: begin
        word_nxt.side = operand_a_i + operand_b_i;
      end
      OP_SUB: begin
        word_nxt.side = operand_a_i - operand_b_i;
      end
      OP_MUL: begin
        word_nxt.side = prod;
      end
      OP_DIV: begin
        if (operand_b_i == ZERO) word_nxt.status = ST_DIV0;
      end
      OP_REM: begin
        if (operand_b_i == ZERO) word_nxt.status = ST_MOD0;
      end
      default: begin
        word_nxt.status = ST_BADOP;
      end
    endcase
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  // request word
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign vld_o  = vld_r;
  assign word_o = word_r;

endmodule

[hdl/sia_div_stage.sv]
module sia_div_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  sia_pkg::sia_word_t word_i,
  output logic               vld_o,
  output sia_pkg::sia_word_t word_o
);
  import sia_pkg::*;

  logic                  vld_r;
  sia_word_t             word_r;
  sia_word_t             word_nxt;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;
  logic                  q_bit;

  // one restoring step: shift in the next dividend bit, try the subtract
  assign rem_sh = {word_i.rem, word_i.quo[DATA_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, word_i.divisor};
  assign q_bit  = ~diff[DATA_WIDTH];

  always_comb begin
    word_nxt     = word_i;
    word_nxt.rem = q_bit ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
    word_nxt.quo = {word_i.quo[DATA_WIDTH-2:0], q_bit};
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  // request word
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign vld_o  = vld_r;
  assign word_o = word_r;

endmodule

[hdl/sia_post.sv]
module sia_post (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           vld_i,
  input  sia_pkg::sia_word_t             word_i,
  output logic                           strobe_o,
  output logic [sia_pkg::DATA_WIDTH-1:0] result_o,
  output logic [1:0]                     status_o
);
  import sia_pkg::*;

  localparam logic [DATA_WIDTH-1:0] ONE  = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
  localparam logic [DATA_WIDTH-1:0] ZERO = '0;

  logic                  strobe_r;
  logic [DATA_WIDTH-1:0] result_r;
  logic [DATA_WIDTH-1:0] result_nxt;
  logic [1:0]            status_r;
  logic [DATA_WIDTH-1:0] quo_s;
  logic [DATA_WIDTH-1:0] rem_s;

  // restore signs of quotient and remainder
  assign quo_s = word_i.neg_q ? (~word_i.quo + ONE) : word_i.quo;
  assign rem_s = word_i.neg_r ? (~word_i.rem + ONE) : word_i.rem;

  // result select, zero on any error
  always_comb begin
    case (word_i.op)
      OP_DIV:  result_nxt = quo_s;
      OP_REM:  result_nxt = rem_s;
      default: result_nxt = word_i.side;
    endcase
    if (word_i.status != ST_OK) result_nxt = ZERO;
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vld_i;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    result_r <= result_nxt;
    status_r <= word_i.status;
  end

  assign strobe_o = strobe_r;
  assign result_o = result_r;
  assign status_o = status_r;

endmodule

[hdl/signed_integer_alu_core.sv]
// channel   ports                                       handshake
// --------  ------------------------------------------  ------------------------------
// request   in_req_type, in_operand_a, in_operand_b     start high and busy low
// result    out_result, out_status                      out_strobe high for one cycle
//
// a request enters every cycle; busy stays low since nothing ever holds the pipe
// the pipe has one decode stage, one stage per quotient bit
// of the restoring divider, and one sign and select stage
// every operation takes the same path so results leave in request order
// synchronous active-low reset clears the valid bits only
module signed_integer_alu_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           in_req_type,
  input  logic signed [sia_pkg::DATA_WIDTH-1:0] in_operand_a,
  input  logic signed [sia_pkg::DATA_WIDTH-1:0] in_operand_b,
  output logic                                 out_strobe,
  output logic signed [sia_pkg::DATA_WIDTH-1:0] out_result,
  output logic [1:0]                           out_status
);
  import sia_pkg::*;

  logic                  stage_vld  [0:DATA_WIDTH];
  sia_word_t             stage_word [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] result_u;

  // the pipe never stalls
  assign busy = 1'b0;

  // decode, add, subtract, multiply, magnitudes
  sia_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .vld_i       (start),
    .req_type_i  (in_req_type),
    .operand_a_i ($unsigned(in_operand_a)),
    .operand_b_i ($unsigned(in_operand_b)),
    .vld_o       (stage_vld[0]),
    .word_o      (stage_word[0])
  );

  // divider, one quotient bit per stage
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_div
    sia_div_stage u_div_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (stage_vld[i]),
      .word_i (stage_word[i]),
      .vld_o  (stage_vld[i+1]),
      .word_o (stage_word[i+1])
    );
  end

  // sign fix and result select
  sia_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (stage_vld[DATA_WIDTH]),
    .word_i   (stage_word[DATA_WIDTH]),
    .strobe_o (out_strobe),
    .result_o (result_u),
    .status_o (out_status)
  );

  assign out_result = $signed(result_u);

endmodule
